/* hw/rtl/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int MAG_W  = 31;  // normalized component magnitude, top bit at 2^30
  localparam int SUM_W  = 64;  // sum of four squared magnitudes
  localparam int ROOT_W = 32;  // integer square root of the sum
  localparam int SREM_W = 35;  // square root partial remainder
  localparam int DREM_W = 33;  // division partial remainder, below twice the root
  localparam int LANES  = 4;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               invalid;
  } out_t;

  // Control that travels with every transaction along the chains.
  typedef struct packed {
    logic             valid;
    logic             inv;
    logic [LANES-1:0] neg;
  } tag_t;

endpackage
`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// Top level: rotation matrix to normalized quaternion converter.
`timescale 1ns / 1ps
`default_nettype none
// The converter is a fixed pipeline that takes one matrix every clock cycle
// (busy is always low) and returns its quaternion; components are Q1.14 at
// the default FRAC_BITS. The pipeline is built from two rows of
// cells: 32 square root cells, one per root bit of the 64-bit sum of squares,
// and FRAC_BITS + 1 division cells, one quotient bit per cell for all four
// lanes; eight more register stages form the branch components, normalize
// them, square, sum, prepare the dividend and saturate. The result appears
// for one cycle with out_valid high and cannot be held off, so the receiver
// must take every transaction as it comes. A matrix whose branch radicand is
// not positive comes back with invalid set and all four components zero.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int CW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 3;
  localparam int QW = FRAC_BITS + 1;
  localparam int DW = MAG_W + FRAC_BITS + 1;

  // ---------------- stage 1: branch choice and raw components ----------------
  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, one, tr;
  logic signed [CW-1:0] r_c;
  logic signed [LANES-1:0][CW-1:0] c_c;
  logic signed [LANES-1:0][CW-1:0] c_r;
  tag_t t1_r;

  assign busy = 1'b0;

  always_comb begin
    e00 = CW'(in_data.m00); e01 = CW'(in_data.m01); e02 = CW'(in_data.m02);
    e10 = CW'(in_data.m10); e11 = CW'(in_data.m11); e12 = CW'(in_data.m12);
    e20 = CW'(in_data.m20); e21 = CW'(in_data.m21); e22 = CW'(in_data.m22);
    one = CW'(1) <<< FRAC_BITS;
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      r_c = one + tr;
      c_c[0] = e21 - e12; c_c[1] = e02 - e20; c_c[2] = e10 - e01; c_c[3] = r_c;
    end else if (e00 > e11 && e00 > e22) begin
      r_c = one + e00 - e11 - e22;
      c_c[0] = r_c; c_c[1] = e01 + e10; c_c[2] = e20 + e02; c_c[3] = e21 - e12;
    end else if (e11 > e22) begin
      r_c = one + e11 - e00 - e22;
      c_c[0] = e01 + e10; c_c[1] = r_c; c_c[2] = e12 + e21; c_c[3] = e02 - e20;
    end else begin
      r_c = one + e22 - e00 - e11;
      c_c[0] = e02 + e20; c_c[1] = e12 + e21; c_c[2] = r_c; c_c[3] = e10 - e01;
    end
  end

  // ---------------- stage 2: magnitudes and their maximum ----------------
  logic [LANES-1:0][CW-1:0] abs_r;
  logic [CW-1:0]            mx_r;
  logic [CW-1:0]            mx_c;
  logic [LANES-1:0][CW-1:0] abs_c;
  tag_t t2_r;

  always_comb begin
    mx_c = '0;
    for (int i = 0; i < LANES; i++) begin
      abs_c[i] = c_r[i][CW-1] ? CW'(-c_r[i]) : CW'(c_r[i]);
      if (abs_c[i] > mx_c) mx_c = abs_c[i];
    end
  end

  // ---------------- stage 3: common left shift to put the top at 2^30 -------
  logic [LANES-1:0][MAG_W-1:0] mag3_r;
  logic [5:0]                  msb_c;
  logic [5:0]                  sh_c;
  logic [63:0]                 wide_c;
  logic [LANES-1:0][MAG_W-1:0] mag3_c;
  tag_t t3_r;

  always_comb begin
    msb_c  = 6'd30;
    wide_c = '0;
    for (int i = 0; i < CW; i++) begin
      if (mx_r[i]) msb_c = 6'(i);
    end
    sh_c = 6'd30 - msb_c;
    for (int i = 0; i < LANES; i++) begin
      wide_c    = 64'(abs_r[i]) << sh_c;
      mag3_c[i] = wide_c[MAG_W-1:0];
    end
  end

  // ---------------- stages 4 to 6: squares and their sum ----------------
  logic [LANES-1:0][2*MAG_W-1:0] sq_r;
  logic [2*MAG_W:0]              p01_r, p23_r;
  logic [SUM_W-1:0]              sum_r;
  logic [LANES-1:0][MAG_W-1:0]   mag4_r, mag5_r, mag6_r;
  tag_t t4_r, t5_r, t6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid <= 1'b0;
      t2_r.valid <= 1'b0;
      t3_r.valid <= 1'b0;
      t4_r.valid <= 1'b0;
      t5_r.valid <= 1'b0;
      t6_r.valid <= 1'b0;
    end else begin
      t1_r.valid <= start;
      t2_r.valid <= t1_r.valid;
      t3_r.valid <= t2_r.valid;
      t4_r.valid <= t3_r.valid;
      t5_r.valid <= t4_r.valid;
      t6_r.valid <= t5_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_r.inv <= (r_c <= 0);
    t1_r.neg <= '0;
    c_r      <= c_c;
    t2_r.inv <= t1_r.inv;
    for (int i = 0; i < LANES; i++) begin
      t2_r.neg[i] <= c_r[i][CW-1];
    end
    abs_r    <= abs_c;
    mx_r     <= mx_c;
    t3_r.inv <= t2_r.inv;
    t3_r.neg <= t2_r.neg;
    mag3_r   <= mag3_c;
    t4_r.inv <= t3_r.inv;
    t4_r.neg <= t3_r.neg;
    mag4_r   <= mag3_r;
    for (int i = 0; i < LANES; i++) begin
      sq_r[i] <= mag3_r[i] * mag3_r[i];
    end
    t5_r.inv <= t4_r.inv;
    t5_r.neg <= t4_r.neg;
    mag5_r   <= mag4_r;
    p01_r    <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    p23_r    <= {1'b0, sq_r[2]} + {1'b0, sq_r[3]};
    t6_r.inv <= t5_r.inv;
    t6_r.neg <= t5_r.neg;
    mag6_r   <= mag5_r;
    sum_r    <= SUM_W'(p01_r) + SUM_W'(p23_r);
  end

  // ---------------- square root chain ----------------
  tag_t                        sq_tag  [0:ROOT_W];
  logic [LANES-1:0][MAG_W-1:0] sq_mag  [0:ROOT_W];
  logic [SUM_W-1:0]            sq_sum  [0:ROOT_W];
  logic [SREM_W-1:0]           sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]           sq_root [0:ROOT_W];

  assign sq_tag[0]  = t6_r;
  assign sq_mag[0]  = mag6_r;
  assign sq_sum[0]  = sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    rmq_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tag_i  (sq_tag[j]),
      .mag_i  (sq_mag[j]),
      .sum_i  (sq_sum[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .tag_o  (sq_tag[j+1]),
      .mag_o  (sq_mag[j+1]),
      .sum_o  (sq_sum[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // ---------------- dividend preparation: scale and add half the root --------
  tag_t                         dv_tag [0:QW];
  logic [LANES-1:0][DW-1:0]     dv_num [0:QW];
  logic [ROOT_W-1:0]            dv_den [0:QW];
  logic [LANES-1:0][DREM_W-1:0] dv_rem [0:QW];
  logic [LANES-1:0][QW-1:0]     dv_quo [0:QW];
  logic [LANES-1:0][DW-1:0]     num_c;
  logic [LANES-1:0][DREM_W-1:0] rem0_c;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      num_c[i]  = (DW'(sq_mag[ROOT_W][i]) << FRAC_BITS) + DW'(sq_root[ROOT_W] >> 1);
      rem0_c[i] = DREM_W'(num_c[i] >> QW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_tag[0].valid <= 1'b0;
    end else begin
      dv_tag[0].valid <= sq_tag[ROOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    dv_tag[0].inv <= sq_tag[ROOT_W].inv;
    dv_tag[0].neg <= sq_tag[ROOT_W].neg;
    dv_num[0]     <= num_c;
    dv_den[0]     <= sq_root[ROOT_W];
    dv_rem[0]     <= rem0_c;
    dv_quo[0]     <= '0;
  end

  // ---------------- division chain ----------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    rmq_div_cell #(.BIT(FRAC_BITS - j), .DW(DW), .QW(QW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (dv_tag[j]),
      .num_i (dv_num[j]),
      .den_i (dv_den[j]),
      .rem_i (dv_rem[j]),
      .quo_i (dv_quo[j]),
      .tag_o (dv_tag[j+1]),
      .num_o (dv_num[j+1]),
      .den_o (dv_den[j+1]),
      .rem_o (dv_rem[j+1]),
      .quo_o (dv_quo[j+1])
    );
  end

  // Output stage: sign, saturate, zero the components of invalid results.
  logic [LANES-1:0][15:0] res_c;
  logic [31:0]            qe;

  always_comb begin
    qe = '0;
    for (int i = 0; i < LANES; i++) begin
      qe = 32'(dv_quo[QW][i]);
      if (dv_tag[QW].inv) begin
        res_c[i] = '0;
      end else if (dv_tag[QW].neg[i]) begin
        res_c[i] = (qe > 32'd32768) ? 16'h8000 : 16'(-qe);
      end else begin
        res_c[i] = (qe > 32'd32767) ? 16'h7fff : qe[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_tag[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data.qx      <= res_c[0];
    out_data.qy      <= res_c[1];
    out_data.qz      <= res_c[2];
    out_data.qw      <= res_c[3];
    out_data.invalid <= dv_tag[QW].inv;
  end

`ifndef NO_ASSERTIONS
  // An invalid result carries all-zero components.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |->
      out_data.qx == 0 && out_data.qy == 0 && out_data.qz == 0 && out_data.qw == 0)
    else $error("invalid result with nonzero components");

  // The starting division remainder of lanes 0 and 3 lies below the root of its item.
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_tag[0].valid && !dv_tag[0].inv |->
      dv_rem[0][0] < DREM_W'(dv_den[0]) && dv_rem[0][3] < DREM_W'(dv_den[0]))
    else $error("dividend start exceeds root");

  // The pipeline never pushes back.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
`endif

endmodule
`default_nettype wire

/* hw/rtl/rmq_sqrt_cell.sv */
// One digit step of the integer square root chain.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tag_t                        tag_i,
  input  wire logic [LANES-1:0][MAG_W-1:0] mag_i,
  input  wire logic [SUM_W-1:0]            sum_i,
  input  wire logic [SREM_W-1:0]           rem_i,
  input  wire logic [ROOT_W-1:0]           root_i,
  output tag_t                             tag_o,
  output logic [LANES-1:0][MAG_W-1:0]      mag_o,
  output logic [SUM_W-1:0]                 sum_o,
  output logic [SREM_W-1:0]                rem_o,
  output logic [ROOT_W-1:0]                root_o
);

  logic [SREM_W-1:0] rem_s;
  logic [SREM_W-1:0] trial;
  logic              take;

  // Bring down the next two radicand bits and try the odd trial value.
  assign rem_s = {rem_i[SREM_W-3:0], sum_i[2*BIT+1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign take  = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_o.valid <= 1'b0;
    end else begin
      tag_o.valid <= tag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_o.inv <= tag_i.inv;
    tag_o.neg <= tag_i.neg;
    mag_o     <= mag_i;
    sum_o     <= sum_i;
    rem_o     <= take ? rem_s - trial : rem_s;
    root_o    <= {root_i[ROOT_W-2:0], take};
  end

endmodule
`default_nettype wire

/* hw/rtl/rmq_div_cell.sv */
// One quotient bit of the four-lane restoring division chain.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell import rmq_pkg::*; #(
  parameter int BIT = 0,
  parameter int DW  = 46,
  parameter int QW  = 15
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tag_t                         tag_i,
  input  wire logic [LANES-1:0][DW-1:0]     num_i,
  input  wire logic [ROOT_W-1:0]            den_i,
  input  wire logic [LANES-1:0][DREM_W-1:0] rem_i,
  input  wire logic [LANES-1:0][QW-1:0]     quo_i,
  output tag_t                              tag_o,
  output logic [LANES-1:0][DW-1:0]          num_o,
  output logic [ROOT_W-1:0]                 den_o,
  output logic [LANES-1:0][DREM_W-1:0]      rem_o,
  output logic [LANES-1:0][QW-1:0]          quo_o
);

  logic [LANES-1:0][DREM_W-1:0] rem_s;
  logic [LANES-1:0]             take;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rem_s[i] = {rem_i[i][DREM_W-2:0], num_i[i][BIT]};
      take[i]  = rem_s[i] >= {1'b0, den_i};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_o.valid <= 1'b0;
    end else begin
      tag_o.valid <= tag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_o.inv <= tag_i.inv;
    tag_o.neg <= tag_i.neg;
    num_o     <= num_i;
    den_o     <= den_i;
    for (int i = 0; i < LANES; i++) begin
      rem_o[i] <= take[i] ? rem_s[i] - {1'b0, den_i} : rem_s[i];
      quo_o[i] <= {quo_i[i][QW-2:0], take[i]};
    end
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the rotation matrix to quaternion converter: random and directed matrices.
`timescale 1ns / 1ps
module tb_top;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 41 + FRAC;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  in_t matrix_q[$];        // matrices waiting to be driven
  out_t quat_expected_q[$]; // quaternions predicted, oldest first
  int idle_pct;             // chance in 100 that the driver idles on a given clock
  bit hold_for_drain;       // pause the driver until every result is back
  int error_count;
  int cycle_count;

  // Saturate a sign and magnitude to a 16-bit signed value.
  function automatic logic signed [15:0] clamp16(bit neg, longint unsigned mag);
    if (neg) return (mag > 32768) ? -16'sd32768 : 16'(-longint'(mag));
    return (mag > 32767) ? 16'sd32767 : 16'(mag);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Predict the quaternion for one matrix.
  function automatic out_t matrix_to_quat(in_t m);
    out_t q;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
    longint comp[4];
    longint unsigned mag[4];
    bit neg[4];
    longint unsigned mx, sum, n, quo;
    int sh;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      rad = (64'sd1 << FRAC) + tr;
      comp = '{a21 - a12, a02 - a20, a10 - a01, rad};
    end else if (a00 > a11 && a00 > a22) begin
      rad = (64'sd1 << FRAC) + a00 - a11 - a22;
      comp = '{rad, a01 + a10, a20 + a02, a21 - a12};
    end else if (a11 > a22) begin
      rad = (64'sd1 << FRAC) + a11 - a00 - a22;
      comp = '{a01 + a10, rad, a12 + a21, a02 - a20};
    end else begin
      rad = (64'sd1 << FRAC) + a22 - a00 - a11;
      comp = '{a02 + a20, a12 + a21, rad, a10 - a01};
    end
    q = '0;
    if (rad <= 0) begin
      q.invalid = 1'b1;
      return q;
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? -comp[i] : comp[i];
      if (mag[i] > mx) mx = mag[i];
    end
    sh = 0;
    while ((mx << sh) < (64'd1 << 30)) sh++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] <<= sh;
      sum += mag[i] * mag[i];
    end
    n = root64(sum);
    for (int i = 0; i < 4; i++) begin
      quo = ((mag[i] << FRAC) + (n >> 1)) / n;
      case (i)
        0: q.qx = clamp16(neg[i], quo);
        1: q.qy = clamp16(neg[i], quo);
        2: q.qz = clamp16(neg[i], quo);
        default: q.qw = clamp16(neg[i], quo);
      endcase
    end
    return q;
  endfunction

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      2: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
    endcase
  endfunction

  // Build a near-rotation: a random axis-permutation with signs, then jitter.
  function automatic in_t rand_rotation();
    in_t m;
    logic signed [15:0] e[9];
    int p;
    p = $urandom_range(0, 5);
    for (int i = 0; i < 9; i++) e[i] = 16'($signed($urandom_range(0, 600)) - 300);
    for (int r = 0; r < 3; r++) begin
      int c;
      c = (r + p) % 3;
      if (p >= 3) c = (3 - r + p) % 3;
      e[r * 3 + c] = ($urandom_range(0, 1) ? 16'sd16000 : -16'sd16000)
                     + 16'($signed($urandom_range(0, 700)) - 350);
    end
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: present the head of the queue, advance on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        quat_expected_q.push_back(matrix_to_quat(in_data));
        void'(matrix_q.pop_front());
      end
      if (matrix_q.size() > 0 && !(start && !busy && matrix_q.size() == 0)
          && !hold_for_drain && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_data <= matrix_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare every strobed result with the oldest prediction.
  always @(posedge clk) begin
    out_t exp_q;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (quat_expected_q.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        error_count++;
      end else begin
        exp_q = quat_expected_q.pop_front();
        if (out_data.qx !== exp_q.qx) begin
          $error("qx expected %0d got %0d", exp_q.qx, out_data.qx); error_count++;
        end
        if (out_data.qy !== exp_q.qy) begin
          $error("qy expected %0d got %0d", exp_q.qy, out_data.qy); error_count++;
        end
        if (out_data.qz !== exp_q.qz) begin
          $error("qz expected %0d got %0d", exp_q.qz, out_data.qz); error_count++;
        end
        if (out_data.qw !== exp_q.qw) begin
          $error("qw expected %0d got %0d", exp_q.qw, out_data.qw); error_count++;
        end
        if (out_data.invalid !== exp_q.invalid) begin
          $error("invalid expected %0b got %0b", exp_q.invalid, out_data.invalid);
          error_count++;
        end
      end
    end
  end

  // Hold until the driver has sent everything queued.
  task automatic drain_stimulus();
    while (matrix_q.size() > 0 || start) @(posedge clk);
  endtask

  initial begin
    in_t m;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct = 0;
    hold_for_drain = 1'b0;
    error_count = 0;
    cycle_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, extremes, each branch, ties.
    matrix_q.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                        16'sd0, 16'sd0, 16'sd16384});
    matrix_q.push_back({9{16'sh7fff}});
    matrix_q.push_back({9{16'sh8000}});
    matrix_q.push_back('0);
    matrix_q.push_back({16'sd16384, 16'sd5, 16'sd7, 16'sd3, -16'sd16384, 16'sd0,
                        16'sd9, 16'sd0, -16'sd16384});
    matrix_q.push_back({-16'sd16384, 16'sd5, 16'sd0, 16'sd3, 16'sd16384, 16'sd4,
                        16'sd0, 16'sd8, -16'sd16384});
    matrix_q.push_back({-16'sd16384, 16'sd0, 16'sd5, 16'sd0, -16'sd16384, 16'sd6,
                        16'sd2, 16'sd1, 16'sd16384});
    // ties on the diagonal go to the later branch
    matrix_q.push_back({-16'sd100, 16'sd1, 16'sd2, 16'sd3, -16'sd100, 16'sd4,
                        16'sd5, 16'sd6, -16'sd100});
    matrix_q.push_back({16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd0, 16'sd4,
                        16'sd5, 16'sd6, -16'sd10});
    // a diagonal of -1.0, a large mixed diagonal, and saturated off-diagonal entries
    matrix_q.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                        16'sd0, 16'sd0, -16'sd16384});
    matrix_q.push_back({-16'sd30000, 16'sd0, 16'sd0, 16'sd0, 16'sd8000, 16'sd0,
                        16'sd0, 16'sd0, 16'sd30000});
    matrix_q.push_back({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, -16'sd1,
                        16'sh7fff, 16'sh8000, 16'sh7fff, 16'sd0});
    drain_stimulus();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 52 : (ph == 3) ? 9 : 0;
      for (int k = 0; k < 375; k++) begin
        if ($urandom_range(0, 99) < 70) m = rand_rotation();
        else m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                  rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        matrix_q.push_back(m);
      end
      drain_stimulus();
      if (ph == 1) begin
        // pause the sender until every result is back
        hold_for_drain = 1'b1;
        while (quat_expected_q.size() > 0) @(posedge clk);
        hold_for_drain = 1'b0;
      end
    end

    while (quat_expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
